>>> rtl/lfpd_pkg.sv
// ----------------------------------------------------------------------------
// lfpd_pkg
// Shared types, constants and the control store of the PID line follower
// drive block.
// ----------------------------------------------------------------------------
`default_nettype none

package lfpd_pkg;

  // Fixed field widths
  localparam int GAIN_W     = 16;
  localparam int SPEED_W    = 7;
  localparam int POS_W      = 13;
  localparam int TIME_W     = 32;
  localparam int RAMP_W     = 16;
  localparam int CORR_W     = 24;
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int ERR_W      = POS_W + 1;

  // Parameter defaults
  localparam int PAST_ERRORS_DEF    = 5;
  localparam int GAIN_FRAC_BITS_DEF = 16;

  // Commands
  typedef enum logic [CMD_W-1:0] {
    CMD_NONE  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P         = 3'd0,
    REG_GAIN_D         = 3'd1,
    REG_GAIN_I         = 3'd2,
    REG_TARGET_SPEED   = 3'd3,
    REG_RAMP_TIME_MS   = 3'd4,
    REG_MAX_CORRECTION = 3'd5,
    REG_MAX_SPEED      = 3'd6,
    REG_LINE_CENTER    = 3'd7
  } cfg_reg_t;

  // Register reset values
  localparam logic [GAIN_W-1:0]  GAIN_P_RST         = GAIN_W'(862);
  localparam logic [GAIN_W-1:0]  GAIN_D_RST         = GAIN_W'(11469);
  localparam logic [GAIN_W-1:0]  GAIN_I_RST         = GAIN_W'(56);
  localparam logic [SPEED_W-1:0] TARGET_SPEED_RST   = SPEED_W'(40);
  localparam logic [RAMP_W-1:0]  RAMP_TIME_RST      = RAMP_W'(3000);
  localparam logic [SPEED_W-1:0] MAX_CORRECTION_RST = SPEED_W'(40);
  localparam logic [SPEED_W-1:0] MAX_SPEED_RST      = SPEED_W'(90);
  localparam logic [POS_W-1:0]   LINE_CENTER_RST    = POS_W'(4250);

  // Edge zones of the line position
  localparam logic [POS_W-1:0] EDGE_LOW_MAX  = POS_W'(1000);
  localparam logic [POS_W-1:0] EDGE_HIGH_MIN = POS_W'(6000);
  localparam logic [POS_W-1:0] POS_FULL      = POS_W'(7000);

  // Edge speed = floor(target * 85 / 100) by reciprocal multiply
  localparam int EDGE_PERCENT = 85;
  localparam int EDGE_DEN     = 100;
  localparam int EDGE_SHIFT   = 20;
  localparam int EDGE_RECIP   = (1 << EDGE_SHIFT) / EDGE_DEN + 1;
  localparam int EDGE_MUL     = EDGE_PERCENT * EDGE_RECIP;
  localparam int EDGE_PROD_W  = SPEED_W + EDGE_SHIFT;

  // Ramp divider: quotient never exceeds the target speed
  localparam int DIV_W = RAMP_W + SPEED_W;
  localparam int K_W   = $clog2(SPEED_W);

  // Microcode
  localparam int PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [3:0] {
    OP_LOAD,
    OP_PREP,
    OP_RAMP_MUL,
    OP_DIV_STEP,
    OP_INTEG_ADD,
    OP_BASE,
    OP_MUL_P,
    OP_MUL_D,
    OP_MUL_I,
    OP_ACC,
    OP_CLAMP_HI,
    OP_CLAMP_LO,
    OP_WHEEL_L,
    OP_WHEEL_R,
    OP_EDGE,
    OP_FINISH
  } uop_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_NO_IN,
    C_OUT_BUSY,
    C_DIV_MORE,
    C_IDX_MORE
  } cond_t;

  typedef struct packed {
    uop_t  op;
    cond_t cond;
    pc_t   target;
  } uword_t;

  localparam pc_t PC_IDLE   = pc_t'(0);
  localparam pc_t PC_DIV    = pc_t'(3);
  localparam pc_t PC_INTEG  = pc_t'(4);
  localparam pc_t PC_FINISH = pc_t'(15);
  localparam int  UCODE_LEN = 1 << PC_W;

  // Control store: jump to target when the condition holds, else advance
  localparam uword_t UCODE [UCODE_LEN] = '{
    '{op: OP_LOAD,      cond: C_NO_IN,    target: PC_IDLE},
    '{op: OP_PREP,      cond: C_NEVER,    target: PC_IDLE},
    '{op: OP_RAMP_MUL,  cond: C_NEVER,    target: PC_IDLE},
    '{op: OP_DIV_STEP,  cond: C_DIV_MORE, target: PC_DIV},
    '{op: OP_INTEG_ADD, cond: C_IDX_MORE, target: PC_INTEG},
    '{op: OP_BASE,      cond: C_NEVER,    target: PC_IDLE},
    '{op: OP_MUL_P,     cond: C_NEVER,    target: PC_IDLE},
    '{op: OP_MUL_D,     cond: C_NEVER,    target: PC_IDLE},
    '{op: OP_MUL_I,     cond: C_NEVER,    target: PC_IDLE},
    '{op: OP_ACC,       cond: C_NEVER,    target: PC_IDLE},
    '{op: OP_CLAMP_HI,  cond: C_NEVER,    target: PC_IDLE},
    '{op: OP_CLAMP_LO,  cond: C_NEVER,    target: PC_IDLE},
    '{op: OP_WHEEL_L,   cond: C_NEVER,    target: PC_IDLE},
    '{op: OP_WHEEL_R,   cond: C_NEVER,    target: PC_IDLE},
    '{op: OP_EDGE,      cond: C_NEVER,    target: PC_IDLE},
    '{op: OP_FINISH,    cond: C_OUT_BUSY, target: PC_FINISH}
  };

endpackage

`default_nettype wire

>>> rtl/line_follow_pid_drive.sv
// ----------------------------------------------------------------------------
// line_follow_pid_drive
// PID line follower with differential drive, run by a microcoded sequencer
// over one shared multiplier, a restoring divider and a small accumulator.
// ----------------------------------------------------------------------------
// One item is processed at a time: a new input is taken only after the
// result of the last one is registered. The microprogram runs seven
// restoring divide steps for the speed ramp, one accumulate step per stored
// error for the windowed integral, and the ramp product and three gain
// products through the single shared multiplier. If the previous result
// has not been taken, the last step waits and the item completes once the
// output register frees.
`default_nettype none

module line_follow_pid_drive #(
  parameter int PAST_ERRORS    = lfpd_pkg::PAST_ERRORS_DEF,
  parameter int GAIN_FRAC_BITS = lfpd_pkg::GAIN_FRAC_BITS_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  // configuration write port
  input  wire                                  cfg_we,
  input  wire  [lfpd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [lfpd_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  // input channel
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire  [lfpd_pkg::CMD_W-1:0]           in_command,
  input  wire  [lfpd_pkg::TIME_W-1:0]          in_now_ms,
  input  wire  [lfpd_pkg::POS_W-1:0]           in_line_position,
  // result channel
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic [lfpd_pkg::SPEED_W-1:0]         out_left_speed,
  output logic [lfpd_pkg::SPEED_W-1:0]         out_right_speed,
  output logic signed [lfpd_pkg::CORR_W-1:0]   out_correction_q16,
  output logic                                 out_running
);
  import lfpd_pkg::*;

  // Datapath widths
  localparam int INTEG_W  = POS_W + $clog2(PAST_ERRORS + 2) + 1;
  localparam int MA_W     = GAIN_W + 1;
  localparam int PROD_W   = MA_W + INTEG_W;
  localparam int ACC_W    = (PROD_W + 2 > GAIN_FRAC_BITS + SPEED_W + 2) ?
                            PROD_W + 2 : GAIN_FRAC_BITS + SPEED_W + 2;
  localparam int IDX_W    = (PAST_ERRORS > 1) ? $clog2(PAST_ERRORS) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PAST_ERRORS - 1);

  // Configuration registers
  logic [GAIN_W-1:0]  cfg_gain_p_r, cfg_gain_d_r, cfg_gain_i_r;
  logic [SPEED_W-1:0] cfg_target_r, cfg_max_corr_r, cfg_max_speed_r;
  logic [RAMP_W-1:0]  cfg_ramp_r;
  logic [POS_W-1:0]   cfg_center_r;

  // Sequencer
  pc_t    pc_r, pc_nxt;
  uword_t ctl;
  logic   cond_met;

  // Block state
  logic                    run_r;
  logic [TIME_W-1:0]       start_r;
  logic [SPEED_W-1:0]      base_r;
  logic signed [ERR_W-1:0] past_r [PAST_ERRORS];
  logic                    out_valid_r;

  // Working registers
  logic [TIME_W-1:0]         now_r;
  logic [POS_W-1:0]          pos_r;
  logic [RAMP_W-1:0]         elap_r;
  logic                      ramp_ok_r;
  logic                      edge_r;
  logic [SPEED_W-1:0]        edge_base_r;
  logic signed [ERR_W-1:0]   err_r;
  logic signed [INTEG_W-1:0] integ_r, deriv_r;
  logic [IDX_W-1:0]          idx_r;
  logic [DIV_W-1:0]          rem_r;
  logic [SPEED_W-1:0]        quot_r;
  logic [K_W-1:0]            k_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic [SPEED_W-1:0]        left_spd_r, right_spd_r;
  logic [SPEED_W-1:0]        out_left_r, out_right_r;
  logic [CORR_W-1:0]         out_corr_r;
  logic                      out_running_r;

  // Combinational datapath
  logic                      in_xfer, out_busy, finish_go, run_new;
  logic [TIME_W-1:0]         elapsed;
  logic [EDGE_PROD_W-1:0]    edge_prod;
  logic [DIV_W-1:0]          div_cmp;
  logic signed [MA_W-1:0]    mul_a;
  logic signed [INTEG_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic signed [ACC_W-1:0]   lim_s, bq_s, smax_s, wheel_sum;
  logic [SPEED_W-1:0]        wheel_spd;

  // Fetch the control word and pick the next step
  assign ctl = UCODE[pc_r];

  always_comb begin
    unique case (ctl.cond)
      C_NEVER:    cond_met = 1'b0;
      C_NO_IN:    cond_met = !in_valid;
      C_OUT_BUSY: cond_met = out_busy;
      C_DIV_MORE: cond_met = (k_r != '0);
      C_IDX_MORE: cond_met = (idx_r != IDX_LAST);
      default:    cond_met = 1'b0;
    endcase
    pc_nxt = cond_met ? ctl.target : pc_r + pc_t'(1);
  end

  // Handshakes
  assign in_ready  = (ctl.op == OP_LOAD);
  assign in_xfer   = in_valid && in_ready;
  assign out_busy  = out_valid_r && !out_ready;
  assign finish_go = (ctl.op == OP_FINISH) && !out_busy;

  // Apply the command of the incoming transfer
  always_comb begin
    case (cmd_t'(in_command))
      CMD_START: run_new = 1'b1;
      CMD_STOP:  run_new = 1'b0;
      default:   run_new = run_r;
    endcase
  end

  // Ramp time and edge speed
  assign elapsed   = now_r - start_r;
  assign edge_prod = EDGE_PROD_W'(cfg_target_r) * EDGE_PROD_W'(EDGE_MUL);
  assign div_cmp   = DIV_W'(cfg_ramp_r) << k_r;

  // Shared multiplier operand selection
  always_comb begin
    case (ctl.op)
      OP_RAMP_MUL: begin
        mul_a = $signed({1'b0, elap_r});
        mul_b = $signed(INTEG_W'(cfg_target_r));
      end
      OP_MUL_D: begin
        mul_a = $signed({1'b0, cfg_gain_d_r});
        mul_b = deriv_r;
      end
      OP_MUL_I: begin
        mul_a = $signed({1'b0, cfg_gain_i_r});
        mul_b = integ_r;
      end
      default: begin
        mul_a = $signed({1'b0, cfg_gain_p_r});
        mul_b = INTEG_W'(err_r);
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Clamp limits and wheel speed unit
  assign lim_s     = $signed(ACC_W'(cfg_max_corr_r) << GAIN_FRAC_BITS);
  assign bq_s      = $signed(ACC_W'(base_r) << GAIN_FRAC_BITS);
  assign smax_s    = $signed(ACC_W'(cfg_max_speed_r) << GAIN_FRAC_BITS);
  assign wheel_sum = bq_s + ((ctl.op == OP_WHEEL_L) ? -acc_r : acc_r);

  always_comb begin
    if (wheel_sum < 0) begin
      wheel_spd = '0;
    end else if (wheel_sum > smax_s) begin
      wheel_spd = cfg_max_speed_r;
    end else begin
      wheel_spd = wheel_sum[GAIN_FRAC_BITS +: SPEED_W];
    end
  end

  // Control state, configuration and stored history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_gain_p_r    <= GAIN_P_RST;
      cfg_gain_d_r    <= GAIN_D_RST;
      cfg_gain_i_r    <= GAIN_I_RST;
      cfg_target_r    <= TARGET_SPEED_RST;
      cfg_ramp_r      <= RAMP_TIME_RST;
      cfg_max_corr_r  <= MAX_CORRECTION_RST;
      cfg_max_speed_r <= MAX_SPEED_RST;
      cfg_center_r    <= LINE_CENTER_RST;
      pc_r            <= PC_IDLE;
      run_r           <= 1'b0;
      start_r         <= '0;
      base_r          <= '0;
      out_valid_r     <= 1'b0;
      for (int i = 0; i < PAST_ERRORS; i++) begin
        past_r[i] <= '0;
      end
    end else begin
      // register writes
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_GAIN_P:         cfg_gain_p_r    <= cfg_wdata[GAIN_W-1:0];
          REG_GAIN_D:         cfg_gain_d_r    <= cfg_wdata[GAIN_W-1:0];
          REG_GAIN_I:         cfg_gain_i_r    <= cfg_wdata[GAIN_W-1:0];
          REG_TARGET_SPEED:   cfg_target_r    <= cfg_wdata[SPEED_W-1:0];
          REG_RAMP_TIME_MS:   cfg_ramp_r      <= cfg_wdata[RAMP_W-1:0];
          REG_MAX_CORRECTION: cfg_max_corr_r  <= cfg_wdata[SPEED_W-1:0];
          REG_MAX_SPEED:      cfg_max_speed_r <= cfg_wdata[SPEED_W-1:0];
          REG_LINE_CENTER:    cfg_center_r    <= cfg_wdata[POS_W-1:0];
        endcase
      end

      pc_r <= pc_nxt;

      // run flag and start time on transfer
      if (in_xfer) begin
        run_r <= run_new;
        if (start_r == '0 && run_new) begin
          start_r <= in_now_ms;
        end
      end

      // ramp base speed, then age the error history
      if (ctl.op == OP_BASE) begin
        if (ramp_ok_r) begin
          base_r <= (cfg_ramp_r == '0) ? cfg_target_r : quot_r;
        end
        for (int i = PAST_ERRORS - 1; i > 0; i--) begin
          past_r[i] <= past_r[i-1];
        end
        past_r[0] <= err_r;
      end

      // base speed for the next period
      if (ctl.op == OP_EDGE) begin
        base_r <= edge_r ? edge_base_r : cfg_target_r;
      end

      // drop the result once taken, raise it when a new one lands
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (finish_go) begin
        out_valid_r <= 1'b1;
        if (!run_r) begin
          start_r <= '0;
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_LOAD: begin
        if (in_xfer) begin
          now_r <= in_now_ms;
          pos_r <= in_line_position;
        end
      end
      OP_PREP: begin
        elap_r      <= elapsed[RAMP_W-1:0];
        ramp_ok_r   <= (elapsed[TIME_W-1:RAMP_W] == '0) &&
                       (elapsed[RAMP_W-1:0] <= cfg_ramp_r);
        err_r       <= $signed({1'b0, cfg_center_r}) - $signed({1'b0, pos_r});
        edge_r      <= ((pos_r != '0) && (pos_r <= EDGE_LOW_MAX)) ||
                       ((pos_r >= EDGE_HIGH_MIN) && (pos_r < POS_FULL));
        edge_base_r <= edge_prod[EDGE_SHIFT +: SPEED_W];
      end
      OP_RAMP_MUL: begin
        rem_r   <= mul_p[DIV_W-1:0];
        quot_r  <= '0;
        k_r     <= K_W'(SPEED_W - 1);
        integ_r <= INTEG_W'(err_r) + INTEG_W'(err_r);
        deriv_r <= INTEG_W'(err_r) - INTEG_W'(past_r[0]);
        idx_r   <= '0;
      end
      OP_DIV_STEP: begin
        if (rem_r >= div_cmp) begin
          rem_r       <= rem_r - div_cmp;
          quot_r[k_r] <= 1'b1;
        end
        k_r <= k_r - K_W'(1);
      end
      OP_INTEG_ADD: begin
        integ_r <= integ_r + INTEG_W'(past_r[idx_r]);
        idx_r   <= idx_r + IDX_W'(1);
      end
      OP_BASE: begin
        acc_r <= '0;
      end
      OP_MUL_P: begin
        prod_r <= mul_p;
      end
      OP_MUL_D, OP_MUL_I: begin
        acc_r  <= acc_r + ACC_W'(prod_r);
        prod_r <= mul_p;
      end
      OP_ACC: begin
        acc_r <= acc_r + ACC_W'(prod_r);
      end
      OP_CLAMP_HI: begin
        if (acc_r > lim_s) begin
          acc_r <= lim_s;
        end
      end
      OP_CLAMP_LO: begin
        if (acc_r < -lim_s) begin
          acc_r <= -lim_s;
        end
      end
      OP_WHEEL_L: begin
        left_spd_r <= wheel_spd;
      end
      OP_WHEEL_R: begin
        right_spd_r <= wheel_spd;
      end
      OP_FINISH: begin
        if (finish_go) begin
          out_left_r    <= run_r ? left_spd_r : '0;
          out_right_r   <= run_r ? right_spd_r : '0;
          out_corr_r    <= acc_r[CORR_W-1:0];
          out_running_r <= run_r;
        end
      end
      default: begin
      end
    endcase
  end

  // Result ports
  assign out_valid          = out_valid_r;
  assign out_left_speed     = out_left_r;
  assign out_right_speed    = out_right_r;
  assign out_correction_q16 = $signed(out_corr_r);
  assign out_running        = out_running_r;

  // Checks
  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(ctl.op) == OP_FINISH))
    else $error("result raised outside the final step");

  a_stopped_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_running_r) |-> (out_left_r == '0 && out_right_r == '0))
    else $error("wheel speed nonzero while stopped");

  a_corr_low_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == OP_WHEEL_L) |-> (acc_r >= -$past(lim_s)))
    else $error("correction below its clamp at the wheel step");

  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == OP_DIV_STEP && k_r == '0) |=> (ctl.op == OP_INTEG_ADD))
    else $error("divider loop did not exit to the integral walk");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second input taken while an item is in work");

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the PID line follower drive block. A scoreboard
// object predicts each wheel speed result from the accepted control periods
// and the programmed gains, then matches it field by field against the
// result transfers. Directed periods cover edge zones, start/stop, time wrap
// and zero ramp; random run segments follow under several configurations.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lfpd_pkg::*;

  localparam int HIST_DEPTH      = PAST_ERRORS_DEF;
  localparam int FRAC            = GAIN_FRAC_BITS_DEF;
  localparam int LEFT_EDGE_END   = 1000;
  localparam int RIGHT_EDGE_FROM = 6000;
  localparam int TRACK_END       = 7000;
  localparam int EDGE_SPEED_PCT  = 85;
  localparam int SETTLE_CYCLES   = 40;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int RAND_PHASES     = 9;
  localparam int PHASE_ITEMS     = 100;

  typedef struct packed {
    logic [SPEED_W-1:0]       left;
    logic [SPEED_W-1:0]       right;
    logic signed [CORR_W-1:0] corr;
    logic                     run;
  } drive_out_t;

  // Drive predictor plus the queue of wheel commands still owed by the block
  class drive_scoreboard;
    logic [GAIN_W-1:0]  kp, kd, ki;
    logic [SPEED_W-1:0] target, corr_cap, speed_cap;
    logic [RAMP_W-1:0]  ramp_ms;
    logic [POS_W-1:0]   center;
    bit                 running;
    logic [TIME_W-1:0]  t_start;
    logic [SPEED_W-1:0] base;
    int                 err_hist[HIST_DEPTH];
    drive_out_t         owed_q[$];
    int                 errors;

    function new();
      errors = 0;
      kp = GAIN_P_RST;
      kd = GAIN_D_RST;
      ki = GAIN_I_RST;
      target = TARGET_SPEED_RST;
      ramp_ms = RAMP_TIME_RST;
      corr_cap = MAX_CORRECTION_RST;
      speed_cap = MAX_SPEED_RST;
      center = LINE_CENTER_RST;
      running = 0;
      t_start = '0;
      base = '0;
      foreach (err_hist[i]) err_hist[i] = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_GAIN_P:         kp = data[GAIN_W-1:0];
        REG_GAIN_D:         kd = data[GAIN_W-1:0];
        REG_GAIN_I:         ki = data[GAIN_W-1:0];
        REG_TARGET_SPEED:   target = data[SPEED_W-1:0];
        REG_RAMP_TIME_MS:   ramp_ms = data[RAMP_W-1:0];
        REG_MAX_CORRECTION: corr_cap = data[SPEED_W-1:0];
        REG_MAX_SPEED:      speed_cap = data[SPEED_W-1:0];
        REG_LINE_CENTER:    center = data[POS_W-1:0];
        default: ;
      endcase
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    // Run one control period and queue the wheel command it yields
    function void note_input(cmd_t cmd, logic [TIME_W-1:0] now, logic [POS_W-1:0] pos);
      logic [TIME_W-1:0] elapsed;
      int                err, integ, deriv;
      longint            pid, cap, base_q, top, lq, rq;
      drive_out_t        res;
      if (cmd == CMD_START) running = 1;
      else if (cmd == CMD_STOP) running = 0;
      if (t_start == 0 && running) t_start = now;
      elapsed = now - t_start;
      // linear ramp of the base speed
      if (elapsed <= TIME_W'(ramp_ms)) begin
        if (ramp_ms == 0) base = target;
        else base = SPEED_W'((64'(elapsed) * 64'(target)) / 64'(ramp_ms));
      end
      // error, windowed integral (current error twice) and derivative
      err = int'(center) - int'(pos);
      integ = 2 * err;
      foreach (err_hist[i]) integ += err_hist[i];
      deriv = err - err_hist[0];
      for (int i = HIST_DEPTH - 1; i > 0; i--) err_hist[i] = err_hist[i-1];
      err_hist[0] = err;
      pid = longint'(kp) * err + longint'(kd) * deriv + longint'(ki) * integ;
      cap = longint'(corr_cap) << FRAC;
      pid = clip(pid, -cap, cap);
      // wheel speeds in fixed point, then truncate
      base_q = longint'(base) << FRAC;
      top = longint'(speed_cap) << FRAC;
      lq = clip(base_q - pid, 0, top);
      rq = clip(base_q + pid, 0, top);
      res.left = SPEED_W'(lq >> FRAC);
      res.right = SPEED_W'(rq >> FRAC);
      res.corr = CORR_W'(pid);
      res.run = running;
      // base speed for the next period: slow down near the edges
      if ((pos > 0 && pos <= LEFT_EDGE_END) || (pos >= RIGHT_EDGE_FROM && pos < TRACK_END))
        base = SPEED_W'(int'(target) * EDGE_SPEED_PCT / 100);
      else
        base = target;
      if (!running) begin
        res.left = '0;
        res.right = '0;
        t_start = '0;
      end
      owed_q.push_back(res);
    endfunction

    function void check_result(input logic [SPEED_W-1:0] left, input logic [SPEED_W-1:0] right,
                               input logic signed [CORR_W-1:0] corr, input logic run);
      drive_out_t want;
      if (owed_q.size() == 0) begin
        $error("result transfer with nothing owed: left %0d right %0d correction %0d running %0d",
               left, right, corr, run);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (left !== want.left) begin
        $error("left_speed: expected %0d, actual %0d", want.left, left);
        errors++;
      end
      if (right !== want.right) begin
        $error("right_speed: expected %0d, actual %0d", want.right, right);
        errors++;
      end
      if (corr !== want.corr) begin
        $error("correction_q16: expected %0d, actual %0d", want.corr, corr);
        errors++;
      end
      if (run !== want.run) begin
        $error("running: expected %0d, actual %0d", want.run, run);
        errors++;
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  cfg_reg_t                 cfg_index = REG_GAIN_P;
  logic [CFG_DATA_W-1:0]    cfg_wdata = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  cmd_t                     in_command = CMD_NONE;
  logic [TIME_W-1:0]        in_now_ms = '0;
  logic [POS_W-1:0]         in_line_position = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [SPEED_W-1:0]       out_left_speed, out_right_speed;
  logic signed [CORR_W-1:0] out_correction_q16;
  logic                     out_running;

  drive_scoreboard sb = new();
  int              tx_idle_pct = 0;
  int              rx_idle_pct = 0;
  int              rx_hold = 0;
  int unsigned     cycle_count = 0;

  line_follow_pid_drive uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_command         (in_command),
    .in_now_ms          (in_now_ms),
    .in_line_position   (in_line_position),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_left_speed     (out_left_speed),
    .out_right_speed    (out_right_speed),
    .out_correction_q16 (out_correction_q16),
    .out_running        (out_running)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Check each result transfer, then stall the result side in random bursts
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_left_speed, out_right_speed, out_correction_q16, out_running);
    if (rx_hold > 0) begin
      rx_hold--;
      out_ready <= 1'b0;
    end else if ($urandom_range(1, 100) <= rx_idle_pct) begin
      rx_hold = $urandom_range(0, 6);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Present one control period, hold it until the transfer, then predict
  task automatic send_period(input cmd_t cmd, input logic [TIME_W-1:0] now,
                             input logic [POS_W-1:0] pos);
    if ($urandom_range(1, 100) <= tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_now_ms <= now;
    in_line_position <= pos;
    do @(posedge clk); while (!in_ready);
    sb.note_input(cmd, now, pos);
  endtask

  // Drop valid and wait for every owed result
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // Write all registers; narrow ones carry junk in the unused upper bits
  task automatic program_gains(input logic [GAIN_W-1:0] gp, input logic [GAIN_W-1:0] gd,
                               input logic [GAIN_W-1:0] gi, input logic [SPEED_W-1:0] ts,
                               input logic [RAMP_W-1:0] rt, input logic [SPEED_W-1:0] mc,
                               input logic [SPEED_W-1:0] ms, input logic [POS_W-1:0] lc);
    cfg_write(REG_GAIN_P, gp);
    cfg_write(REG_GAIN_D, gd);
    cfg_write(REG_GAIN_I, gi);
    cfg_write(REG_TARGET_SPEED, {9'($urandom), ts});
    cfg_write(REG_RAMP_TIME_MS, rt);
    cfg_write(REG_MAX_CORRECTION, {9'($urandom), mc});
    cfg_write(REG_MAX_SPEED, {9'($urandom), ms});
    cfg_write(REG_LINE_CENTER, {3'($urandom), lc});
    cfg_we <= 1'b0;
  endtask

  function automatic logic [GAIN_W-1:0] rand_gain(int typical);
    if ($urandom_range(0, 3) == 0) return GAIN_W'($urandom);
    return GAIN_W'($urandom_range(0, typical));
  endfunction

  // Random run segments: start, cruise with a wandering line, stop; some noise
  task automatic run_segments(input int n_items);
    int                seg_left;
    int                walk;
    int                max_step;
    int                pick;
    cmd_t              cmd;
    logic [TIME_W-1:0] t_ms;
    logic [POS_W-1:0]  pos;
    seg_left = 0;
    t_ms = $urandom;
    walk = $urandom_range(0, TRACK_END);
    max_step = int'(sb.ramp_ms) / 12 + 3;
    repeat (n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        cmd = cmd_t'($urandom_range(0, 3));
      end else if (seg_left == 0) begin
        if ($urandom_range(0, 3) == 0) begin
          cmd = CMD_NONE;
        end else begin
          cmd = CMD_START;
          seg_left = $urandom_range(3, 40);
        end
      end else if (seg_left == 1) begin
        cmd = CMD_STOP;
        seg_left = 0;
      end else begin
        cmd = CMD_NONE;
        seg_left--;
      end
      // time mostly advances in small steps scaled to the ramp time, sometimes jumps anywhere
      if (pick < 4) t_ms = $urandom;
      else if (cmd == CMD_START && $urandom_range(0, 9) == 0) t_ms = '0;
      else t_ms = t_ms + $urandom_range(0, max_step);
      if (pick >= 92) begin
        pos = $urandom_range(0, (1 << POS_W) - 1);
      end else if (pick >= 86) begin
        case ($urandom_range(0, 5))
          0: pos = 0;
          1: pos = 1;
          2: pos = LEFT_EDGE_END;
          3: pos = RIGHT_EDGE_FROM;
          4: pos = TRACK_END - 1;
          default: pos = TRACK_END;
        endcase
      end else begin
        walk = walk + int'($urandom_range(0, 600)) - 300;
        if (walk < 0) walk = 0;
        if (walk > TRACK_END) walk = TRACK_END;
        pos = walk;
      end
      send_period(cmd, t_ms, pos);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    tx_idle_pct = 30;
    rx_idle_pct = 30;

    // Directed: stopped periods, start at time zero, edge zones, time wrap
    send_period(CMD_NONE, 100, 0);
    send_period(CMD_NOP, 200, 8191);
    send_period(CMD_STOP, 300, 4250);
    send_period(CMD_START, 0, 4250);
    send_period(CMD_NONE, 1000, 4000);
    send_period(CMD_NONE, 1500, 1);
    send_period(CMD_NONE, 2000, 1000);
    send_period(CMD_NONE, 2500, 1001);
    send_period(CMD_NONE, 3000, 5999);
    send_period(CMD_NONE, 3500, 6000);
    send_period(CMD_NONE, 4000, 6999);
    send_period(CMD_NONE, 4001, 7000);
    send_period(CMD_NONE, 4100, 7001);
    send_period(CMD_NONE, 4200, 8191);
    send_period(CMD_START, 4300, 0);
    send_period(CMD_STOP, 4400, 3000);
    send_period(CMD_START, 32'hFFFF_FF00, 4250);
    send_period(CMD_NONE, 32'h0000_0200, 2000);
    send_period(CMD_NONE, 32'hFFFF_FFFF, 4300);

    // Directed: every other register at its top value, zero ramp time
    drain();
    program_gains('1, '1, '1, '1, '0, '1, '1, '1);
    send_period(CMD_START, 5000, 0);
    send_period(CMD_NONE, 5001, 8191);
    send_period(CMD_NONE, 5002, 4000);
    send_period(CMD_STOP, 5003, 7000);

    // Random phases, each under its own configuration; the last one runs flat out
    for (int p = 0; p < RAND_PHASES; p++) begin
      drain();
      tx_idle_pct = (p == RAND_PHASES - 1) ? 0 : $urandom_range(10, 40);
      rx_idle_pct = (p == RAND_PHASES - 1) ? 0 : $urandom_range(10, 40);
      case (p)
        0: program_gains('0, '0, '0, '0, '0, '0, '0, '0);
        1: program_gains(GAIN_P_RST, GAIN_D_RST, GAIN_I_RST, TARGET_SPEED_RST,
                         RAMP_TIME_RST, MAX_CORRECTION_RST, MAX_SPEED_RST, LINE_CENTER_RST);
        2: program_gains('1, '1, '1, '1, '1, '1, '1, '1);
        3: program_gains(rand_gain(2000), rand_gain(20000), rand_gain(200),
                         $urandom_range(0, 127), 1, $urandom_range(0, 127),
                         $urandom_range(0, 127), $urandom_range(3000, 5000));
        default: program_gains(rand_gain(2000), rand_gain(20000), rand_gain(200),
                               $urandom_range(0, 127), $urandom_range(1, 5000),
                               $urandom_range(0, 127), $urandom_range(0, 127),
                               ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191)
                                                           : $urandom_range(3000, 5000));
      endcase
      run_segments(PHASE_ITEMS);
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
rtl/lfpd_pkg.sv
rtl/line_follow_pid_drive.sv
tb/sv/testbench.sv
